@@ hdl/spl_pkg.sv @@
// Shared types and constants for the strict priority level queues.
// No dependencies; imported by every module of the block.
package spl_pkg;

    localparam int LEVELS_DEF      = 5;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int STATUS_W = 3;
    localparam int LEVEL_W  = 3;
    localparam int TAG_W    = 32;
    localparam int TOTAL_W  = 7;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_SERVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_SERVED    = 3'd1,
        ST_BAD_LEVEL = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    // What the back end does with the tag store for one item
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                  op;
        t_status              status;
        logic [LEVEL_W-1:0]   level;
        logic [TOTAL_W-1:0]   total;
    } t_cmd_ctl;

endpackage

@@ hdl/strict_priority_level_queues.sv @@
// Strict priority level queues: LEVELS ring-buffer queues of 32-bit tags,
// level 1 most urgent. Each input item is an add (action 0) or a serve
// (action 1) and answers with exactly one result item.
// Input channel: i_valid / o_stall with i_action, i_urgency, i_payload.
// Output channel: o_valid / i_stall with o_status, o_served_level,
// o_served_payload, o_total_waiting.
// An item is taken when valid is high and stall is low on that channel.
// An accepted item is registered in the command queue, then in the back
// end's output register, where its result is valid; one item per cycle is
// sustained while the receiver does not stall, one single-port tag store access each.
// A two-entry command queue sits between classification and store access,
// so input keeps flowing while the receiver stalls until the queue fills;
// then o_stall rises. A stalled result holds its value.
// Reset (synchronous, active low) empties every level at once; the tag
// store itself is not cleared, only entries written by an add are read.
// Depends on spl_pkg, spl_front, spl_cmd_fifo, spl_back.
module strict_priority_level_queues #(
    parameter int LEVELS      = spl_pkg::LEVELS_DEF,
    parameter int QUEUE_DEPTH = spl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_action,
    input  logic [2:0]                    i_urgency,
    input  logic [spl_pkg::TAG_W-1:0]     i_payload,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [spl_pkg::STATUS_W-1:0]  o_status,
    output logic [spl_pkg::LEVEL_W-1:0]   o_served_level,
    output logic [spl_pkg::TAG_W-1:0]     o_served_payload,
    output logic [spl_pkg::TOTAL_W-1:0]   o_total_waiting
);
    import spl_pkg::*;

    localparam int ADDR_W = $clog2(LEVELS*QUEUE_DEPTH);

    logic              w_push;
    t_cmd_ctl          w_push_ctl;
    logic [ADDR_W-1:0] w_push_addr;
    logic [TAG_W-1:0]  w_push_data;
    logic              w_full;
    logic              w_pop;
    logic              w_cmd_valid;
    t_cmd_ctl          w_cmd_ctl;
    logic [ADDR_W-1:0] w_cmd_addr;
    logic [TAG_W-1:0]  w_cmd_data;

    spl_front #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_action  (i_action),
        .i_urgency (i_urgency),
        .i_payload (i_payload),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_ctl     (w_push_ctl),
        .o_addr    (w_push_addr),
        .o_data    (w_push_data)
    );

    spl_cmd_fifo #(
        .ADDR_W (ADDR_W)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ctl   (w_push_ctl),
        .i_addr  (w_push_addr),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_cmd_valid),
        .o_ctl   (w_cmd_ctl),
        .o_addr  (w_cmd_addr),
        .o_data  (w_cmd_data)
    );

    spl_back #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (w_cmd_valid),
        .i_ctl            (w_cmd_ctl),
        .i_addr           (w_cmd_addr),
        .i_data           (w_cmd_data),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_served_level   (o_served_level),
        .o_served_payload (o_served_payload),
        .o_total_waiting  (o_total_waiting)
    );

endmodule

@@ hdl/spl_front.sv @@
// Front end: accepts items, keeps per-level ring pointers and counts,
// classifies each item and issues one store command. Uses spl_pkg.
module spl_front #(
    parameter int LEVELS      = spl_pkg::LEVELS_DEF,
    parameter int QUEUE_DEPTH = spl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_action,
    input  logic [2:0]                             i_urgency,
    input  logic [spl_pkg::TAG_W-1:0]              i_payload,
    input  logic                                   i_full,
    output logic                                   o_push,
    output spl_pkg::t_cmd_ctl                      o_ctl,
    output logic [$clog2(LEVELS*QUEUE_DEPTH)-1:0]  o_addr,
    output logic [spl_pkg::TAG_W-1:0]              o_data
);
    import spl_pkg::*;

    localparam int ADDR_W = $clog2(LEVELS*QUEUE_DEPTH);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    logic [PTR_W-1:0]   r_head  [LEVELS];
    logic [PTR_W-1:0]   r_tail  [LEVELS];
    logic [CNT_W-1:0]   r_count [LEVELS];
    logic [TOTAL_W-1:0] r_total;

    logic             w_accept;
    logic             w_lvl_ok;
    logic [LVL_W-1:0] w_add_q;
    logic             w_full;
    logic             w_any;
    logic [LVL_W-1:0] w_sel;
    logic             w_do_add;
    logic             w_do_serve;
    logic [PTR_W-1:0] w_slot;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
        return (slot == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : slot + PTR_W'(1);
    endfunction

    assign w_accept = i_valid && !i_full;
    assign o_stall  = i_full;
    assign o_push   = w_accept;
    assign o_data   = i_payload;

    always_comb begin
        w_lvl_ok = (i_urgency != 3'd0) && (int'(i_urgency) <= LEVELS);
        w_add_q  = LVL_W'(i_urgency - 3'd1);
        w_full   = w_lvl_ok && (r_count[w_add_q] == CNT_W'(QUEUE_DEPTH));
    end

    // Lowest level number with anything waiting wins
    always_comb begin
        w_any = 1'b0;
        w_sel = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                w_any = 1'b1;
                w_sel = LVL_W'(i);
            end
        end
    end

    always_comb begin
        w_do_add   = (i_action == ACT_ADD) && w_lvl_ok && !w_full;
        w_do_serve = (i_action == ACT_SERVE) && w_any;
        o_ctl.op     = OP_NONE;
        o_ctl.status = ST_EMPTY;
        o_ctl.level  = '0;
        o_ctl.total  = r_total;
        w_slot       = r_tail[w_add_q];
        if (i_action == ACT_ADD) begin
            if (!w_lvl_ok) begin
                o_ctl.status = ST_BAD_LEVEL;
            end else if (w_full) begin
                o_ctl.status = ST_FULL;
            end else begin
                o_ctl.op     = OP_WRITE;
                o_ctl.status = ST_ADDED;
                o_ctl.total  = r_total + TOTAL_W'(1);
            end
        end else if (w_any) begin
            w_slot       = r_head[w_sel];
            o_ctl.op     = OP_READ;
            o_ctl.status = ST_SERVED;
            o_ctl.level  = LEVEL_W'(w_sel) + LEVEL_W'(1);
            o_ctl.total  = r_total - TOTAL_W'(1);
        end
        o_addr = ADDR_W'((i_action == ACT_SERVE) ? w_sel : w_add_q) * ADDR_W'(QUEUE_DEPTH)
                 + ADDR_W'(w_slot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
            r_total <= '0;
        end else if (w_accept) begin
            if (w_do_add) begin
                r_tail[w_add_q]  <= next_slot(r_tail[w_add_q]);
                r_count[w_add_q] <= r_count[w_add_q] + CNT_W'(1);
                r_total          <= r_total + TOTAL_W'(1);
            end
            if (w_do_serve) begin
                r_head[w_sel]  <= next_slot(r_head[w_sel]);
                r_count[w_sel] <= r_count[w_sel] - CNT_W'(1);
                r_total        <= r_total - TOTAL_W'(1);
            end
        end
    end

    a_add_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_do_add |=> r_total == $past(r_total) + TOTAL_W'(1))
        else $error("total did not grow after an add");

    a_serve_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_do_serve |-> (o_ctl.op == OP_READ) && (o_ctl.level != '0))
        else $error("serve issued without a store read");

    a_add_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_do_add |=> r_count[$past(w_add_q)] != '0)
        else $error("level still empty after an add");

endmodule

@@ hdl/spl_cmd_fifo.sv @@
// Two-entry command queue between the front and back ends.
// Uses spl_pkg for the command control struct.
module spl_cmd_fifo #(
    parameter int ADDR_W = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  spl_pkg::t_cmd_ctl         i_ctl,
    input  logic [ADDR_W-1:0]         i_addr,
    input  logic [spl_pkg::TAG_W-1:0] i_data,
    output logic                      o_full,
    input  logic                      i_pop,
    output logic                      o_valid,
    output spl_pkg::t_cmd_ctl         o_ctl,
    output logic [ADDR_W-1:0]         o_addr,
    output logic [spl_pkg::TAG_W-1:0] o_data
);
    import spl_pkg::*;

    t_cmd_ctl          r_ctl  [2];
    logic [ADDR_W-1:0] r_addr [2];
    logic [TAG_W-1:0]  r_data [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;
    assign o_ctl   = r_ctl[r_rd_ptr];
    assign o_addr  = r_addr[r_rd_ptr];
    assign o_data  = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ctl[r_wr_ptr]  <= i_ctl;
            r_addr[r_wr_ptr] <= i_addr;
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hdl/spl_back.sv @@
// Back end: owns the tag store, carries out write/read commands and holds
// the result in an output register. Uses spl_pkg.
module spl_back #(
    parameter int LEVELS      = spl_pkg::LEVELS_DEF,
    parameter int QUEUE_DEPTH = spl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cmd_valid,
    input  spl_pkg::t_cmd_ctl                      i_ctl,
    input  logic [$clog2(LEVELS*QUEUE_DEPTH)-1:0]  i_addr,
    input  logic [spl_pkg::TAG_W-1:0]              i_data,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [spl_pkg::STATUS_W-1:0]           o_status,
    output logic [spl_pkg::LEVEL_W-1:0]            o_served_level,
    output logic [spl_pkg::TAG_W-1:0]              o_served_payload,
    output logic [spl_pkg::TOTAL_W-1:0]            o_total_waiting
);
    import spl_pkg::*;

    localparam int STORE_DEPTH = LEVELS * QUEUE_DEPTH;

    logic [TAG_W-1:0] r_mem [STORE_DEPTH];
    logic [TAG_W-1:0] r_rd_data;
    t_cmd_ctl         r_out_ctl;
    logic             r_out_valid;

    assign o_pop = i_cmd_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Store access happens only when the output register loads, so the
    // read data stays put while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_ctl <= i_ctl;
            if (i_ctl.op == OP_WRITE) begin
                r_mem[i_addr] <= i_data;
            end
            if (i_ctl.op == OP_READ) begin
                r_rd_data <= r_mem[i_addr];
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_ctl.status;
    assign o_served_level   = r_out_ctl.level;
    assign o_served_payload = (r_out_ctl.op == OP_READ) ? r_rd_data : '0;
    assign o_total_waiting  = r_out_ctl.total;

endmodule
